@@ rtl/tlp_pkg.sv @@
// Shared types, widths and saturating helpers for the target track and lead point block.
`timescale 1ns / 1ps
package tlp_pkg;
    localparam int CoordBits = 32;
    localparam int MulW      = CoordBits + 1;
    localparam int DivN      = 73;
    localparam int DivM      = 24;
    localparam int QuoW      = CoordBits - 1;
    localparam int RootW     = CoordBits + 1;

    typedef logic signed [CoordBits-1:0] t_coord;

    typedef enum logic [1:0] {
        FUNC_MEAS  = 2'd0,
        FUNC_PRED  = 2'd1,
        FUNC_QUERY = 2'd2,
        FUNC_NOP   = 2'd3
    } t_func;

    localparam t_coord CoordMax = {1'b0, {(CoordBits-1){1'b1}}};
    localparam t_coord CoordMin = {1'b1, {(CoordBits-1){1'b0}}};

    // a + b, clamped to the coordinate range
    function automatic t_coord sat_add(t_coord a, t_coord b);
        logic signed [CoordBits:0] s;
        s = {a[CoordBits-1], a} + {b[CoordBits-1], b};
        if (s[CoordBits] != s[CoordBits-1]) begin
            sat_add = s[CoordBits] ? CoordMin : CoordMax;
        end else begin
            sat_add = s[CoordBits-1:0];
        end
    endfunction

    // signed value from sign and magnitude; ovf means magnitude is past the range
    function automatic t_coord from_mag(logic neg, logic ovf, logic [QuoW-1:0] q);
        t_coord m;
        m = {1'b0, q};
        if (ovf) begin
            from_mag = neg ? CoordMin : CoordMax;
        end else begin
            from_mag = neg ? -m : m;
        end
    endfunction

    // |a - b|, one bit wider than a coordinate
    function automatic logic [CoordBits:0] abs_diff(t_coord a, t_coord b);
        logic signed [CoordBits:0] d;
        d = {a[CoordBits-1], a} - {b[CoordBits-1], b};
        abs_diff = d[CoordBits] ? (CoordBits+1)'(-d) : (CoordBits+1)'(d);
    endfunction
endpackage

@@ rtl/tlp_mul.sv @@
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module tlp_mul #(
    parameter int W = 33
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [W-1:0]   i_a,
    input  logic [W-1:0]   i_b,
    output logic           o_done,
    output logic [2*W-1:0] o_prod
);
    localparam int CntW = $clog2(W + 1);

    logic [W-1:0]    r_a;
    logic [W-1:0]    r_hi;
    logic [W-1:0]    r_lo;
    logic [CntW-1:0] r_cnt;
    logic            r_busy;
    logic            r_done;
    logic [W:0]      n_sum;

    // add the multiplicand when the current multiplier bit is set
    assign n_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_hi   <= '0;
                r_lo   <= i_b;
                r_cnt  <= CntW'(W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_hi  <= n_sum[W:1];
                r_lo  <= {n_sum[0], r_lo[W-1:1]};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CntW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi, r_lo};
endmodule

@@ rtl/tlp_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle, with overflow flag.
`timescale 1ns / 1ps
module tlp_div #(
    parameter int N = 73,
    parameter int M = 24,
    parameter int Q = 31
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [N-1:0] i_dividend,
    input  logic [M-1:0] i_divisor,
    output logic         o_done,
    output logic [Q-1:0] o_quo,
    output logic         o_ovf
);
    localparam int CntW = $clog2(N + 1);

    logic [N-1:0]    r_n;
    logic [M-1:0]    r_d;
    logic [M-1:0]    r_r;
    logic [Q-1:0]    r_q;
    logic            r_ovf;
    logic [CntW-1:0] r_cnt;
    logic            r_busy;
    logic            r_done;
    logic [M:0]      n_t;
    logic [M:0]      n_diff;
    logic            n_ge;

    // trial subtract of the divisor from the partial remainder
    assign n_t    = {r_r, r_n[N-1]};
    assign n_ge   = n_t >= {1'b0, r_d};
    assign n_diff = n_t - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_n    <= i_dividend;
                r_d    <= i_divisor;
                r_r    <= '0;
                r_q    <= '0;
                r_ovf  <= 1'b0;
                r_cnt  <= CntW'(N);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_n   <= {r_n[N-2:0], 1'b0};
                r_r   <= n_ge ? n_diff[M-1:0] : n_t[M-1:0];
                r_q   <= {r_q[Q-2:0], n_ge};
                // any bit pushed out of the top means the quotient is too large
                r_ovf <= r_ovf | r_q[Q-1];
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CntW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
    assign o_ovf  = r_ovf;
endmodule

@@ rtl/tlp_sqrt.sv @@
// Digit-serial integer square root, two radicand bits and one root bit per cycle.
`timescale 1ns / 1ps
module tlp_sqrt #(
    parameter int W = 33
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [2*W-1:0] i_rad,
    output logic           o_done,
    output logic [W-1:0]   o_root
);
    localparam int CntW = $clog2(W + 1);

    logic [2*W-1:0]  r_x;
    logic [W+1:0]    r_rem;
    logic [W-1:0]    r_root;
    logic [CntW-1:0] r_cnt;
    logic            r_busy;
    logic            r_done;
    logic [W+3:0]    n_t;
    logic [W+3:0]    n_trial;
    logic            n_ge;

    // remainder with the next bit pair against 4*root + 1
    assign n_t     = {r_rem, r_x[2*W-1:2*W-2]};
    assign n_trial = {2'b00, r_root, 2'b01};
    assign n_ge    = n_t >= n_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x    <= i_rad;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= CntW'(W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_x    <= {r_x[2*W-3:0], 2'b00};
                r_rem  <= n_ge ? (W+2)'(n_t - n_trial) : n_t[W+1:0];
                r_root <= {r_root[W-2:0], n_ge};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CntW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

@@ rtl/target_track_and_lead_point.sv @@
// Top level: constant-velocity point track with lead point query.
//
// One item in, one result out. The input stream carries the operation in
// s_axis_tuser (measurement, predict, lead point query) and the point, time
// step and own speed in s_axis_tdata. Each item yields one result item with
// the track position, velocity, lead point (m_axis_tdata) and the tracking
// flag (m_axis_tuser). One item is worked on at a time; s_axis_tready is high
// only while the block is idle.
// A first measurement, a zero-step measurement, and a predict or a query
// before tracking go straight to the result. A later measurement runs the
// serial divider per axis (one quotient bit a cycle); a predict runs the
// serial multiplier per axis; a query runs the serial squares, the square
// root, then multiply and divide per axis. The result is held until
// m_axis_tready is high, and no new item is taken meanwhile.
// Reset (synchronous, active low) clears the track and sets min_speed to
// 1.0 m/s. min_speed is written through i_cfg_wr_en / i_cfg_wr_data; the
// user must do so only while the block is idle, which the block does not enforce.
`timescale 1ns / 1ps
module target_track_and_lead_point (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [15:0]  i_cfg_wr_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: point_x[31:0], point_y[63:32], step_time[79:64], own_speed[95:80]
    input  logic [95:0]  s_axis_tdata,
    // tuser: func[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: track_x, track_y, speed_x, speed_y, lead_x, lead_y (32 bits each, low first)
    output logic [191:0] m_axis_tdata,
    // tuser: tracking[0]
    output logic [0:0]   m_axis_tuser
);
    import tlp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MEAS_DIV, S_MEAS_WAIT, S_PRED_MUL, S_PRED_WAIT, S_SQ_MUL, S_SQ_WAIT,
        S_SQRT_WAIT, S_LEAD_MUL, S_LEAD_MWAIT, S_LEAD_DWAIT, S_OUT
    } t_state;

    t_state         r_state;
    logic           r_axis;
    logic           r_valid;
    logic           r_lead_sel;
    t_coord         r_pos [2];
    t_coord         r_vel [2];
    t_coord         r_last [2];
    t_coord         r_lead [2];
    t_coord         r_pt [2];
    logic [15:0]    r_dt;
    logic [DivM-1:0] r_dvsr;
    logic [2*MulW-1:0] r_sq0;
    logic [RootW-1:0] r_dist;
    logic [15:0]    r_min_speed;

    logic           n_accept;
    t_func          n_func;
    t_coord         n_pt [2];
    logic [15:0]    n_dt;
    logic [15:0]    n_spd;
    logic [15:0]    n_speed;
    t_coord         cur_pos, cur_vel, cur_last, cur_pt;
    logic [CoordBits:0] mag_meas, mag_vel, mag_dx;

    logic           mul_start, mul_done;
    logic [MulW-1:0] mul_a, mul_b;
    logic [2*MulW-1:0] mul_prod;
    logic           div_start, div_done, div_ovf;
    logic [DivN-1:0] div_dvd;
    logic [DivM-1:0] div_dvsr;
    logic [QuoW-1:0] div_quo;
    logic           sqrt_start, sqrt_done;
    logic [2*RootW-1:0] sqrt_rad;
    logic [RootW-1:0] sqrt_root;
    logic [48:0]    pred_round;
    logic [36:0]    pred_shift;
    logic           pred_ovf;
    logic [2*MulW:0] sq_sum;

    // input unpacking
    assign n_accept = s_axis_tvalid && s_axis_tready;
    assign n_func   = t_func'(s_axis_tuser);
    assign n_pt[0]  = s_axis_tdata[31:0];
    assign n_pt[1]  = s_axis_tdata[63:32];
    assign n_dt     = s_axis_tdata[79:64];
    assign n_spd    = s_axis_tdata[95:80];

    // own speed floored at min_speed, never zero
    always_comb begin
        n_speed = (n_spd > r_min_speed) ? n_spd : r_min_speed;
        if (n_speed == 16'd0) begin
            n_speed = 16'd1;
        end
    end

    // per-axis operands
    assign cur_pos  = r_pos[r_axis];
    assign cur_vel  = r_vel[r_axis];
    assign cur_last = r_last[r_axis];
    assign cur_pt   = r_pt[r_axis];
    assign mag_meas = abs_diff(cur_pt, cur_last);
    assign mag_vel  = abs_diff(cur_vel, '0);
    assign mag_dx   = abs_diff(cur_pos, cur_pt);

    // multiplier operand select
    always_comb begin
        mul_start = 1'b0;
        mul_a     = mag_vel;
        mul_b     = {17'd0, r_dt};
        case (r_state)
            S_PRED_MUL: begin
                mul_start = 1'b1;
            end
            S_SQ_MUL: begin
                mul_start = 1'b1;
                mul_a     = mag_dx;
                mul_b     = mag_dx;
            end
            S_LEAD_MUL: begin
                mul_start = 1'b1;
                mul_b     = r_dist;
            end
            default: begin
                mul_start = 1'b0;
            end
        endcase
    end

    // divider: rounded quotient, half the divisor added first
    assign div_start = (r_state == S_MEAS_DIV) || (r_state == S_LEAD_MWAIT && mul_done);
    assign div_dvd   = ((r_state == S_MEAS_DIV) ? {28'd0, mag_meas, 12'd0}
                                                : {mul_prod[64:0], 8'd0})
                       + {50'd0, r_dvsr[DivM-1:1]};
    assign div_dvsr  = r_dvsr;

    // predict offset: (|v| * dt + 2048) >> 12
    assign pred_round = {1'b0, mul_prod[47:0]} + 49'd2048;
    assign pred_shift = pred_round[48:12];
    assign pred_ovf   = |pred_shift[36:QuoW];

    // radicand dx^2 + dy^2
    assign sq_sum     = {1'b0, r_sq0} + {1'b0, mul_prod};
    assign sqrt_rad   = sq_sum[2*MulW-1:0];
    assign sqrt_start = (r_state == S_SQ_WAIT) && mul_done && r_axis;

    tlp_mul #(.W(MulW)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    tlp_div #(.N(DivN), .M(DivM), .Q(QuoW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvsr),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_ovf      (div_ovf)
    );

    tlp_sqrt #(.W(RootW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_rad   (sqrt_rad),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_speed <= 16'd256;
        end else if (i_cfg_wr_en) begin
            r_min_speed <= i_cfg_wr_data;
        end
    end

    // sequencer and track state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_axis     <= 1'b0;
            r_valid    <= 1'b0;
            r_lead_sel <= 1'b0;
            r_pos[0]   <= '0;
            r_pos[1]   <= '0;
            r_vel[0]   <= '0;
            r_vel[1]   <= '0;
            r_last[0]  <= '0;
            r_last[1]  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        r_pt[0]    <= n_pt[0];
                        r_pt[1]    <= n_pt[1];
                        r_dt       <= n_dt;
                        r_axis     <= 1'b0;
                        r_lead_sel <= (n_func == FUNC_QUERY);
                        r_dvsr     <= (n_func == FUNC_MEAS) ? {8'd0, n_dt} : {n_speed, 8'd0};
                        r_state    <= S_OUT;
                        case (n_func)
                            FUNC_MEAS: begin
                                if (!r_valid) begin
                                    r_pos[0]  <= n_pt[0];
                                    r_pos[1]  <= n_pt[1];
                                    r_last[0] <= n_pt[0];
                                    r_last[1] <= n_pt[1];
                                    r_vel[0]  <= '0;
                                    r_vel[1]  <= '0;
                                    r_valid   <= 1'b1;
                                end else if (n_dt != 16'd0) begin
                                    r_state <= S_MEAS_DIV;
                                end
                            end
                            FUNC_PRED: begin
                                if (r_valid) begin
                                    r_state <= S_PRED_MUL;
                                end
                            end
                            FUNC_QUERY: begin
                                r_lead[0] <= n_pt[0];
                                r_lead[1] <= n_pt[1];
                                if (r_valid) begin
                                    r_state <= S_SQ_MUL;
                                end
                            end
                            default: begin
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_MEAS_DIV: begin
                    r_state <= S_MEAS_WAIT;
                end
                S_MEAS_WAIT: begin
                    if (div_done) begin
                        r_vel[r_axis]  <= from_mag(cur_pt < cur_last, div_ovf, div_quo);
                        r_pos[r_axis]  <= cur_pt;
                        r_last[r_axis] <= cur_pt;
                        r_axis         <= 1'b1;
                        r_state        <= r_axis ? S_OUT : S_MEAS_DIV;
                    end
                end
                S_PRED_MUL: begin
                    r_state <= S_PRED_WAIT;
                end
                S_PRED_WAIT: begin
                    if (mul_done) begin
                        r_pos[r_axis] <= sat_add(cur_pos, from_mag(cur_vel < 0, pred_ovf,
                                                                   pred_shift[QuoW-1:0]));
                        r_axis        <= 1'b1;
                        r_state       <= r_axis ? S_OUT : S_PRED_MUL;
                    end
                end
                S_SQ_MUL: begin
                    r_state <= S_SQ_WAIT;
                end
                S_SQ_WAIT: begin
                    if (mul_done) begin
                        r_sq0   <= mul_prod;
                        r_axis  <= ~r_axis;
                        r_state <= r_axis ? S_SQRT_WAIT : S_SQ_MUL;
                    end
                end
                S_SQRT_WAIT: begin
                    if (sqrt_done) begin
                        r_dist  <= sqrt_root;
                        r_state <= S_LEAD_MUL;
                    end
                end
                S_LEAD_MUL: begin
                    r_state <= S_LEAD_MWAIT;
                end
                S_LEAD_MWAIT: begin
                    if (mul_done) begin
                        r_state <= S_LEAD_DWAIT;
                    end
                end
                S_LEAD_DWAIT: begin
                    if (div_done) begin
                        r_lead[r_axis] <= sat_add(cur_pos, from_mag(cur_vel < 0, div_ovf,
                                                                    div_quo));
                        r_axis         <= 1'b1;
                        r_state        <= r_axis ? S_OUT : S_LEAD_MUL;
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result: held in the state registers until taken
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {r_lead_sel ? r_lead[1] : r_pos[1],
                            r_lead_sel ? r_lead[0] : r_pos[0],
                            r_vel[1], r_vel[0], r_pos[1], r_pos[0]};
    assign m_axis_tuser  = r_valid;
endmodule
